/* src/rau_pkg.sv */
package rau_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int DEN_WIDTH     = OPERAND_WIDTH - 1;
	localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
	localparam int SHIFT_WIDTH   = $clog2(PROD_WIDTH + 1);
	localparam int STEP_WIDTH    = $clog2(PROD_WIDTH);
	localparam int NUM_WIDTH     = 32;
	localparam int RDEN_WIDTH    = 31;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	typedef struct packed {
		logic                  err;
		logic                  zero;
		logic                  neg;
		logic [PROD_WIDTH-1:0] nm;
		logic [PROD_WIDTH-1:0] dm;
	} rau_item_t;

endpackage

/* src/rau_front.sv */
module rau_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        req_type,
	input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] left_num,
	input  logic [rau_pkg::DEN_WIDTH-1:0]     left_den,
	input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] right_num,
	input  logic [rau_pkg::DEN_WIDTH-1:0]     right_den,
	output logic                              item_valid,
	input  logic                              item_ready,
	output rau_pkg::rau_item_t                item
);
	localparam int W  = rau_pkg::OPERAND_WIDTH;
	localparam int PW = rau_pkg::PROD_WIDTH;

	logic          v_s1, v_s2;
	logic [1:0]    op_s1, op_s2;
	logic signed [PW-1:0] a_s1, b_s1, c_s1, d_s1;
	logic signed [PW-1:0] p1_s2, p2_s2, p3_s2, rd_s2;
	logic          adv_s2, adv_s1;
	logic signed [PW-1:0] rn;

	assign adv_s2   = !v_s2 || item_ready;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			op_s1 <= req_type;
			a_s1  <= PW'(left_num);
			b_s1  <= {{(PW-W+1){1'b0}}, left_den};
			c_s1  <= PW'(right_num);
			d_s1  <= {{(PW-W+1){1'b0}}, right_den};
		end
		if (adv_s2 && v_s1) begin
			op_s2 <= op_s1;
			// hold a*d and c*b for add/sub; a*c for multiply
			p1_s2 <= a_s1 * d_s1;
			p2_s2 <= c_s1 * b_s1;
			p3_s2 <= a_s1 * c_s1;
			rd_s2 <= (op_s1 == rau_pkg::OP_DIV) ? b_s1 * c_s1 : b_s1 * d_s1;
		end
	end

	always_comb begin
		case (op_s2)
			rau_pkg::OP_ADD: rn = p1_s2 + p2_s2;
			rau_pkg::OP_SUB: rn = p1_s2 - p2_s2;
			rau_pkg::OP_MUL: rn = p3_s2;
			default:         rn = p1_s2;
		endcase
		item.err  = (rd_s2 == '0);
		item.zero = (rn == '0);
		item.neg  = rn[PW-1] ^ rd_s2[PW-1];
		item.nm   = rn[PW-1] ? -rn : rn;
		item.dm   = rd_s2[PW-1] ? -rd_s2 : rd_s2;
	end

	assign item_valid = v_s2;
endmodule

/* src/rau_queue.sv */
module rau_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	output logic               wr_ready,
	input  rau_pkg::rau_item_t wr_item,
	output logic               rd_valid,
	input  logic               rd_ready,
	output rau_pkg::rau_item_t rd_item
);
	rau_pkg::rau_item_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_item  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_item;
	end
endmodule

/* src/rau_back.sv */
module rau_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  rau_pkg::rau_item_t                 item,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [rau_pkg::NUM_WIDTH-1:0] result_num,
	output logic [rau_pkg::RDEN_WIDTH-1:0]     result_den,
	output logic                               status
);
	localparam int PW = rau_pkg::PROD_WIDTH;

	typedef enum logic [2:0] {B_IDLE, B_GCD, B_DIV, B_FIX, B_OUT} state_t;

	state_t state_q;
	logic                           neg_q;
	logic [PW-1:0]                  nm_q, dm_q, a_q, b_q, g_q;
	logic [rau_pkg::SHIFT_WIDTH-1:0] k_q;
	logic [rau_pkg::STEP_WIDTH-1:0]  step_q;
	logic [PW:0]                    rn_rem_q, rd_rem_q;
	logic [PW:0]                    rn_try, rd_try;
	logic [63:0]                    n64;
	logic signed [rau_pkg::NUM_WIDTH-1:0] num_q;
	logic [rau_pkg::RDEN_WIDTH-1:0] den_q;
	logic                           st_q;
	logic signed [rau_pkg::NUM_WIDTH-1:0] num_fix;
	logic [rau_pkg::RDEN_WIDTH-1:0]       den_fix;
	logic [63:0]                          sn64, d64;

	assign item_ready = (state_q == B_IDLE);
	assign out_valid  = (state_q == B_OUT);
	assign result_num = num_q;
	assign result_den = den_q;
	assign status     = st_q;

	assign rn_try = {rn_rem_q[PW-1:0], nm_q[PW-1]};
	assign rd_try = {rd_rem_q[PW-1:0], dm_q[PW-1]};
	assign n64    = {{(64-PW){1'b0}}, nm_q};

	// final sign and width fit of the quotients
	always_comb begin
		sn64    = neg_q ? (64'd0 - n64) : n64;
		d64     = {{(64-PW){1'b0}}, dm_q};
		num_fix = sn64[rau_pkg::NUM_WIDTH-1:0];
		den_fix = d64[rau_pkg::RDEN_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			neg_q <= 1'b0; nm_q <= '0; dm_q <= '0; a_q <= '0; b_q <= '0;
			g_q <= '0; k_q <= '0; step_q <= '0; rn_rem_q <= '0; rd_rem_q <= '0;
			num_q <= '0; den_q <= '0; st_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: if (item_valid) begin
					neg_q <= item.neg;
					nm_q  <= item.nm;
					dm_q  <= item.dm;
					a_q   <= item.nm;
					b_q   <= item.dm;
					k_q   <= '0;
					if (item.err || item.zero) begin
						num_q   <= '0;
						den_q   <= rau_pkg::RDEN_WIDTH'(1);
						st_q    <= item.err;
						state_q <= B_OUT;
					end else begin
						state_q <= B_GCD;
					end
				end
				B_GCD: begin
					// binary gcd: strip common twos, then subtract odd from odd
					if (a_q == b_q) begin
						g_q      <= a_q << k_q;
						rn_rem_q <= '0;
						rd_rem_q <= '0;
						step_q   <= '0;
						state_q  <= B_DIV;
					end else if (!a_q[0] && !b_q[0]) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						k_q <= k_q + 1'b1;
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (a_q > b_q) begin
						a_q <= a_q - b_q;
					end else begin
						b_q <= b_q - a_q;
					end
				end
				B_DIV: begin
					// restoring division of both magnitudes by the gcd, one bit per cycle
					if (rn_try >= {1'b0, g_q}) begin
						rn_rem_q <= rn_try - {1'b0, g_q};
						nm_q     <= {nm_q[PW-2:0], 1'b1};
					end else begin
						rn_rem_q <= rn_try;
						nm_q     <= {nm_q[PW-2:0], 1'b0};
					end
					if (rd_try >= {1'b0, g_q}) begin
						rd_rem_q <= rd_try - {1'b0, g_q};
						dm_q     <= {dm_q[PW-2:0], 1'b1};
					end else begin
						rd_rem_q <= rd_try;
						dm_q     <= {dm_q[PW-2:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (step_q == rau_pkg::STEP_WIDTH'(PW - 1)) begin
						state_q <= B_FIX;
						st_q    <= 1'b0;
					end
				end
				B_FIX: begin
					// quotients are final now; apply the sign and fit the widths
					num_q   <= num_fix;
					den_q   <= den_fix;
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (out_ready) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

/* src/rational_arithmetic_unit.sv */
// Rational arithmetic unit: reduces a op b over two normalized fractions.
// Path: the 2 front stages and the queue, then a load into the back end,
// binary gcd steps, restoring division steps and a sign fix before the result
// is offered; error and zero items go straight to output. One item in the back
// end at a time; the front end and a two-entry queue accept further items
// meanwhile. Reset (arst_n low) empties all pipeline stages and the queue and
// returns the back end to idle.
module rational_arithmetic_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         req_type,
	input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] left_num,
	input  logic [rau_pkg::DEN_WIDTH-1:0]      left_den,
	input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] right_num,
	input  logic [rau_pkg::DEN_WIDTH-1:0]      right_den,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [rau_pkg::NUM_WIDTH-1:0] result_num,
	output logic [rau_pkg::RDEN_WIDTH-1:0]     result_den,
	output logic                               status
);
	logic               f_valid, f_ready, q_valid, q_ready;
	rau_pkg::rau_item_t f_item, q_item;

	rau_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .req_type,
		.left_num, .left_den, .right_num, .right_den,
		.item_valid(f_valid), .item_ready(f_ready), .item(f_item)
	);

	rau_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
	);

	rau_back u_back (
		.clk, .arst_n,
		.item_valid(q_valid), .item_ready(q_ready), .item(q_item),
		.out_valid, .out_ready, .result_num, .result_den, .status
	);
endmodule

/* sim/rational_arithmetic_unit_test.sv */
`timescale 1ns / 1ps

module rational_arithmetic_unit_test;

	typedef struct {
		logic [1:0]                     op;
		logic signed [rau_pkg::OPERAND_WIDTH-1:0] lnum;
		logic [rau_pkg::DEN_WIDTH-1:0]  lden;
		logic signed [rau_pkg::OPERAND_WIDTH-1:0] rnum;
		logic [rau_pkg::DEN_WIDTH-1:0]  rden;
	} operands_t;

	typedef struct {
		logic signed [rau_pkg::NUM_WIDTH-1:0] num;
		logic [rau_pkg::RDEN_WIDTH-1:0]       den;
		logic                                 err;
	} fraction_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] req_type = rau_pkg::OP_ADD;
	logic signed [rau_pkg::OPERAND_WIDTH-1:0] left_num = '0;
	logic [rau_pkg::DEN_WIDTH-1:0] left_den = rau_pkg::DEN_WIDTH'(1);
	logic signed [rau_pkg::OPERAND_WIDTH-1:0] right_num = '0;
	logic [rau_pkg::DEN_WIDTH-1:0] right_den = rau_pkg::DEN_WIDTH'(1);
	logic out_valid;
	logic out_ready = 0;
	logic signed [rau_pkg::NUM_WIDTH-1:0] result_num;
	logic [rau_pkg::RDEN_WIDTH-1:0] result_den;
	logic status;

	operands_t pending_ops[$];
	fraction_t expected_fracs[$];
	int send_idle_pct = 36;
	int recv_idle_pct = 68;
	bit hold_sender = 0;
	bit item_taken = 0;
	int failures = 0;
	int results_seen = 0;
	int div_zero_seen = 0;
	int op_count[4] = '{0, 0, 0, 0};
	longint cycles = 0;

	rational_arithmetic_unit uut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic fraction_t reduce_fraction(operands_t x);
		longint a, b, c, d, rn, rd;
		longint unsigned nm, dm, g, h, t;
		bit neg;
		fraction_t f;
		a = x.lnum;
		b = x.lden;
		c = x.rnum;
		d = x.rden;
		case (x.op)
			rau_pkg::OP_ADD: begin rn = a * d + c * b; rd = b * d; end
			rau_pkg::OP_SUB: begin rn = a * d - c * b; rd = b * d; end
			rau_pkg::OP_MUL: begin rn = a * c; rd = b * d; end
			default: begin rn = a * d; rd = b * c; end
		endcase
		if (rd == 0) begin
			f.num = '0;
			f.den = rau_pkg::RDEN_WIDTH'(1);
			f.err = 1'b1;
			return f;
		end
		neg = (rn < 0) != (rd < 0);
		nm = rn < 0 ? -rn : rn;
		dm = rd < 0 ? -rd : rd;
		g = nm;
		h = dm;
		while (h != 0) begin
			t = g % h;
			g = h;
			h = t;
		end
		nm = nm / g;
		dm = dm / g;
		if (nm == 0) begin
			dm = 1;
			neg = 0;
		end
		if (neg)
			nm = -nm;
		f.num = nm[rau_pkg::NUM_WIDTH-1:0];
		f.den = dm[rau_pkg::RDEN_WIDTH-1:0];
		f.err = 1'b0;
		return f;
	endfunction

	function automatic operands_t make_operands(logic [1:0] op, int ln, int ld, int rn, int rd);
		operands_t x;
		x.op = op;
		x.lnum = ln[rau_pkg::OPERAND_WIDTH-1:0];
		x.lden = ld[rau_pkg::DEN_WIDTH-1:0];
		x.rnum = rn[rau_pkg::OPERAND_WIDTH-1:0];
		x.rden = rd[rau_pkg::DEN_WIDTH-1:0];
		return x;
	endfunction

	function automatic int pick_num();
		case ($urandom_range(5))
			0: return $urandom_range(16) - 8;
			1: return $urandom_range(1) ? -32768 : 32767;
			2: return $urandom_range(200) - 100;
			default: return $signed(16'($urandom));
		endcase
	endfunction

	function automatic int pick_den();
		case ($urandom_range(7))
			0: return $urandom_range(12);
			1: return $urandom_range(1) ? 1 : 32767;
			2: return $urandom_range(1, 300);
			default: return 15'($urandom);
		endcase
	endfunction

	// driver: present a new item once the previous one is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || item_taken) begin
				if (pending_ops.size() > 0 && !hold_sender &&
						$urandom_range(99) >= send_idle_pct) begin
					req_type <= pending_ops[0].op;
					left_num <= pending_ops[0].lnum;
					left_den <= pending_ops[0].lden;
					right_num <= pending_ops[0].rnum;
					right_den <= pending_ops[0].rden;
					void'(pending_ops.pop_front());
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
			out_ready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	// monitor
	always @(posedge clk) begin
		fraction_t want;
		operands_t got;
		cycles++;
		item_taken = in_valid && in_ready;
		if (item_taken) begin
			got.op = req_type;
			got.lnum = left_num;
			got.lden = left_den;
			got.rnum = right_num;
			got.rden = right_den;
			expected_fracs.push_back(reduce_fraction(got));
			op_count[req_type]++;
		end
		if (out_valid && out_ready) begin
			results_seen++;
			if (status)
				div_zero_seen++;
			if (expected_fracs.size() == 0) begin
				$display("%0t: unexpected result %0d/%0d status %0b", $time,
					result_num, result_den, status);
				failures++;
			end else begin
				want = expected_fracs.pop_front();
				if (result_num !== want.num || result_den !== want.den ||
						status !== want.err) begin
					$display("%0t: expected %0d/%0d status %0b, got %0d/%0d status %0b",
						$time, want.num, want.den, want.err,
						result_num, result_den, status);
					failures++;
				end
			end
		end
		if (cycles > 2000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic drain();
		wait (pending_ops.size() == 0);
		@(posedge clk);
		while (in_valid || expected_fracs.size() > 0)
			@(posedge clk);
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++)
			pending_ops.push_back(make_operands(2'($urandom), pick_num(), pick_den(),
				pick_num(), pick_den()));
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1;

		for (int op = 0; op < 4; op++) begin
			pending_ops.push_back(make_operands(2'(op), -32768, 1, 32767, 1));
			pending_ops.push_back(make_operands(2'(op), 32767, 32767, -32768, 32767));
			pending_ops.push_back(make_operands(2'(op), -32768, 32767, -32768, 1));
			pending_ops.push_back(make_operands(2'(op), 0, 5, 3, 7));
			pending_ops.push_back(make_operands(2'(op), 6, 4, 9, 6));
		end
		pending_ops.push_back(make_operands(rau_pkg::OP_DIV, 5, 3, 0, 9));
		pending_ops.push_back(make_operands(rau_pkg::OP_ADD, 1, 0, 1, 2));
		pending_ops.push_back(make_operands(rau_pkg::OP_MUL, 1, 3, 2, 0));
		pending_ops.push_back(make_operands(rau_pkg::OP_SUB, 3, 4, 3, 4));
		queue_random(480);
		drain();

		// hold the sender while more items are queued, then release it with the idle rates swapped
		hold_sender = 1;
		queue_random(40);
		repeat (30) @(posedge clk);
		hold_sender = 0;
		send_idle_pct = 68;
		recv_idle_pct = 36;
		queue_random(480);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(520);
		drain();
		repeat (300) @(posedge clk);

		$display("Checked %0d results (%0d add, %0d sub, %0d mul, %0d div), %0d zero-divide.",
			results_seen, op_count[0], op_count[1], op_count[2], op_count[3],
			div_zero_seen);
		if (failures == 0 && expected_fracs.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* rational_arithmetic_unit.f */
src/rau_pkg.sv
src/rau_front.sv
src/rau_queue.sv
src/rau_back.sv
src/rational_arithmetic_unit.sv
sim/rational_arithmetic_unit_test.sv
